FILE: hw/rtl/irpw_pkg.sv
// irpw_pkg: shared types and constants of the pulse-width ir receiver
// no dependencies; used by the interfaces and every rtl module
`timescale 1ns / 1ps

package irpw_pkg;

    // payload widths
    localparam int LEN_W  = 8;
    localparam int TOL_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register reset values
    localparam logic [TOL_W-1:0] TOLERANCE_RESET    = 6'd2;
    localparam logic [LEN_W-1:0] START_LENGTH_RESET = 8'd24;
    localparam logic [LEN_W-1:0] ZERO_LENGTH_RESET  = 8'd6;
    localparam logic [LEN_W-1:0] ONE_LENGTH_RESET   = 8'd12;

    // pulse counter saturation value
    localparam logic [LEN_W-1:0] LEN_MAX = 8'hFF;

    // dallas crc-8, reflected polynomial
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE    = 2'd0,
        CFG_START_LENGTH = 2'd1,
        CFG_ZERO_LENGTH  = 2'd2,
        CFG_ONE_LENGTH   = 2'd3
    } cfg_index_t;

    // frame status codes
    typedef enum logic [1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_CRC_ERROR = 2'd1,
        STATUS_ZERO_BYTE = 2'd2
    } status_t;

    // frame phase
    typedef enum logic [1:0] {
        PHASE_HUNT = 2'd0,
        PHASE_CMD  = 2'd1,
        PHASE_CRC  = 2'd2
    } phase_t;

    // configuration register set
    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [LEN_W-1:0] start_length;
        logic [LEN_W-1:0] zero_length;
        logic [LEN_W-1:0] one_length;
    } cfg_t;

    // pulse class flags
    typedef struct packed {
        logic is_start;
        logic is_zero;
        logic is_one;
    } pulse_class_t;

    // one completed frame
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        status_t           frame_status;
    } result_t;

endpackage

FILE: hw/rtl/irpw_if.sv
// irpw_if: valid/ready channel interfaces for line samples, frame results and config writes
// depends on irpw_pkg for payload widths
`timescale 1ns / 1ps

// one line sample per transfer
interface irpw_line_if;
    logic valid;
    logic ready;
    logic line_active;

    modport source (output valid, output line_active, input ready);
    modport sink   (input valid, input line_active, output ready);
endinterface

// one decoded frame per transfer
interface irpw_frame_if;
    logic                       valid;
    logic                       ready;
    logic [irpw_pkg::BYTE_W-1:0] data_byte;
    logic [1:0]                 frame_status;

    modport source (output valid, output data_byte, output frame_status, input ready);
    modport sink   (input valid, input data_byte, input frame_status, output ready);
endinterface

// register write channel
interface irpw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [irpw_pkg::CFG_IDX_W-1:0]  index;
    logic [irpw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/ir_pulse_width_receiver_crc8.sv
// ir_pulse_width_receiver_crc8: top level, sample register, config registers, result register
// depends on irpw_pkg, irpw_if and irpw_frame
`timescale 1ns / 1ps

// channel  modport  payload                    role
// line     sink     line_active                one receiver sample per tick
// frame    source   data_byte, frame_status    one decoded frame
// cfg      sink     index, data                register writes, always ready
//
// one sample is taken every cycle unless the line stalls; the sample that ends the closing
// start pulse passes the sample register, then the result register, where the result is valid.
// reset clears the frame state and loads the register defaults.
// line stalls only when a sample that completes a frame waits on a full,
// untaken result register; all other samples keep flowing.

module ir_pulse_width_receiver_crc8
#(
    parameter int BITS_PER_FIELD = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    irpw_line_if.sink          line,
    irpw_frame_if.source       frame,
    irpw_cfg_if.sink           cfg
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_level_reg;
    logic                  s1_advance;
    logic                  produce;
    irpw_pkg::result_t     result;
    irpw_pkg::cfg_t        cfg_reg;
    irpw_pkg::cfg_t        cfg_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    irpw_pkg::result_t     out_reg;
    logic                  out_load;

    // sample stage moves on unless its frame result finds the result register blocked
    assign s1_advance = s1_valid_reg && (!produce || !out_valid_reg || frame.ready);
    assign line.ready = !s1_valid_reg || s1_advance;
    assign out_load   = s1_advance && produce;

    // sample register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (line.ready)
            s1_valid_next = line.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (line.valid && line.ready)
            s1_level_reg <= line.line_active;
    end

    // register writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                irpw_pkg::CFG_TOLERANCE:    cfg_next.tolerance    = cfg.data[irpw_pkg::TOL_W-1:0];
                irpw_pkg::CFG_START_LENGTH: cfg_next.start_length = cfg.data;
                irpw_pkg::CFG_ZERO_LENGTH:  cfg_next.zero_length  = cfg.data;
                irpw_pkg::CFG_ONE_LENGTH:   cfg_next.one_length   = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance    <= irpw_pkg::TOLERANCE_RESET;
            cfg_reg.start_length <= irpw_pkg::START_LENGTH_RESET;
            cfg_reg.zero_length  <= irpw_pkg::ZERO_LENGTH_RESET;
            cfg_reg.one_length   <= irpw_pkg::ONE_LENGTH_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    // frame decoder
    irpw_frame
    #(
        .BITS_PER_FIELD (BITS_PER_FIELD)
    )
    u_frame
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (s1_valid_reg),
        .step         (s1_advance),
        .level        (s1_level_reg),
        .cfg          (cfg_reg),
        .produce      (produce),
        .result       (result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
    end

    assign frame.valid        = out_valid_reg;
    assign frame.data_byte    = out_reg.data_byte;
    assign frame.frame_status = out_reg.frame_status;

`ifndef SYNTHESIS
    // a new result only comes from a sample held in the sample stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg) && $past(produce))
        else $error("result raised without a completing sample");

    // a blocked completing sample stays put
    a_hold_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && produce && out_valid_reg && !frame.ready
        |=> s1_valid_reg && $stable(s1_level_reg))
        else $error("completing sample lost while result register full");

    // an accepted frame never carries a zero byte
    a_accepted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.frame_status == irpw_pkg::STATUS_ACCEPTED)
        |-> out_reg.data_byte != '0)
        else $error("accepted status with zero byte");
`endif

endmodule

FILE: hw/rtl/irpw_classify.sv
// irpw_classify: sorts a finished pulse length into start, zero and one classes
// depends on irpw_pkg for the config struct and class flags
`timescale 1ns / 1ps

module irpw_classify
(
    input  logic [irpw_pkg::LEN_W-1:0] pulse_len,
    input  irpw_pkg::cfg_t             cfg,
    output irpw_pkg::pulse_class_t     pulse_class
);

    // length within tolerance of nominal, bounds widened by one bit so nothing wraps
    function automatic logic fits(
        input logic [irpw_pkg::LEN_W-1:0] len,
        input logic [irpw_pkg::LEN_W-1:0] nominal,
        input logic [irpw_pkg::TOL_W-1:0] tol
    );
        logic [irpw_pkg::LEN_W:0] len_hi;
        logic [irpw_pkg::LEN_W:0] nom_hi;
        len_hi = {1'b0, len} + {{(irpw_pkg::LEN_W - irpw_pkg::TOL_W + 1){1'b0}}, tol};
        nom_hi = {1'b0, nominal} + {{(irpw_pkg::LEN_W - irpw_pkg::TOL_W + 1){1'b0}}, tol};
        return (len_hi >= {1'b0, nominal}) && ({1'b0, len} <= nom_hi);
    endfunction

    // three window compares in parallel
    always_comb
    begin
        pulse_class.is_start = fits(pulse_len, cfg.start_length, cfg.tolerance);
        pulse_class.is_zero  = fits(pulse_len, cfg.zero_length, cfg.tolerance);
        pulse_class.is_one   = fits(pulse_len, cfg.one_length, cfg.tolerance);
    end

endmodule

FILE: hw/rtl/irpw_frame.sv
// irpw_frame: pulse counter, frame phase, command shift and bit-serial crc-8
// depends on irpw_pkg and irpw_classify
`timescale 1ns / 1ps

module irpw_frame
#(
    parameter int BITS_PER_FIELD = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  logic                step,
    input  logic                level,
    input  irpw_pkg::cfg_t      cfg,
    output logic                produce,
    output irpw_pkg::result_t   result
);

    localparam int CW = $clog2(BITS_PER_FIELD + 1);
    localparam logic [CW-1:0] FIELD_BITS = CW'(BITS_PER_FIELD);

    logic                         prev_level_reg;
    logic                         prev_level_next;
    logic [irpw_pkg::LEN_W-1:0]   pulse_len_reg;
    logic [irpw_pkg::LEN_W-1:0]   pulse_len_next;
    irpw_pkg::phase_t             phase_reg;
    irpw_pkg::phase_t             phase_next;
    logic [CW-1:0]                bit_pos_reg;
    logic [CW-1:0]                bit_pos_next;
    logic [irpw_pkg::BYTE_W-1:0]  cmd_reg;
    logic [irpw_pkg::BYTE_W-1:0]  cmd_next;
    logic [irpw_pkg::BYTE_W-1:0]  crc_reg;
    logic [irpw_pkg::BYTE_W-1:0]  crc_next;
    irpw_pkg::pulse_class_t       pulse_class;
    logic                         pulse_end;
    logic                         in_field;
    logic                         rx_bit;
    logic                         crc_fb;

    irpw_classify u_classify
    (
        .pulse_len   (pulse_len_reg),
        .cfg         (cfg),
        .pulse_class (pulse_class)
    );

    // pulse ends on the first inactive sample
    assign pulse_end = !level && prev_level_reg;
    assign in_field  = (phase_reg == irpw_pkg::PHASE_CMD) ||
                       (phase_reg == irpw_pkg::PHASE_CRC);
    assign produce   = sample_valid && pulse_end && pulse_class.is_start &&
                       (phase_reg == irpw_pkg::PHASE_CRC);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pulse_end && pulse_class.is_start)
        begin
            unique case (phase_reg)
                irpw_pkg::PHASE_HUNT: phase_next = irpw_pkg::PHASE_CMD;
                irpw_pkg::PHASE_CMD:  phase_next = irpw_pkg::PHASE_CRC;
                irpw_pkg::PHASE_CRC:  phase_next = irpw_pkg::PHASE_HUNT;
                default:              phase_next = irpw_pkg::PHASE_CMD;
            endcase
        end
    end

    // bit decision and crc feedback
    assign rx_bit = !pulse_class.is_zero && pulse_class.is_one;
    assign crc_fb = crc_reg[0] ^ rx_bit;

    // counter, bit position, command shift and crc
    always_comb
    begin
        prev_level_next = level;
        pulse_len_next  = pulse_len_reg;
        bit_pos_next    = bit_pos_reg;
        cmd_next        = cmd_reg;
        crc_next        = crc_reg;
        if (level)
        begin
            if (pulse_len_reg != irpw_pkg::LEN_MAX)
                pulse_len_next = pulse_len_reg + 1'b1;
        end
        else if (prev_level_reg)
        begin
            pulse_len_next = '0;
            if (in_field)
            begin
                if (pulse_class.is_start)
                    bit_pos_next = '0;
                else if (bit_pos_reg < FIELD_BITS)
                begin
                    if (phase_reg == irpw_pkg::PHASE_CMD)
                    begin
                        for (int i = 0; i < BITS_PER_FIELD; i++)
                        begin
                            if (bit_pos_reg == CW'(i))
                                cmd_next[i] = cmd_reg[i] | rx_bit;
                        end
                    end
                    crc_next     = (crc_reg >> 1) ^ (crc_fb ? irpw_pkg::CRC_POLY : '0);
                    bit_pos_next = bit_pos_reg + 1'b1;
                end
            end
            else if (pulse_class.is_start)
            begin
                bit_pos_next = '0;
                cmd_next     = '0;
                crc_next     = '0;
            end
        end
    end

    // result of a closing start pulse
    always_comb
    begin
        result.data_byte = cmd_reg;
        if (crc_reg != '0)
            result.frame_status = irpw_pkg::STATUS_CRC_ERROR;
        else if (cmd_reg == '0)
            result.frame_status = irpw_pkg::STATUS_ZERO_BYTE;
        else
            result.frame_status = irpw_pkg::STATUS_ACCEPTED;
    end

    // state registers advance once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            pulse_len_reg  <= '0;
            phase_reg      <= irpw_pkg::PHASE_HUNT;
            bit_pos_reg    <= '0;
            cmd_reg        <= '0;
            crc_reg        <= '0;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            pulse_len_reg  <= pulse_len_next;
            phase_reg      <= phase_next;
            bit_pos_reg    <= bit_pos_next;
            cmd_reg        <= cmd_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

FILE: tb/sv/ir_pulse_width_receiver_crc8_test.sv
// ir_pulse_width_receiver_crc8_test: self-checking bench for the pulse-width ir frame receiver
// drives line samples and register writes, predicts each frame and checks the frame channel
// depends on irpw_pkg, irpw_if and the ir_pulse_width_receiver_crc8 rtl
`timescale 1ns / 1ps

module ir_pulse_width_receiver_crc8_test;

    localparam int HALF_PERIOD  = 6;
    localparam int FIELD_BITS   = 8;
    localparam int HOLD_CYCLES  = 1500;
    localparam int HOLD_FRAME   = 1;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int LIMIT_CYCLES = 1000000;

    // how bit pulses are sized when building a frame
    typedef enum int {
        LEN_NOMINAL,
        LEN_EDGE,
        LEN_UNFIT
    } len_style_t;

    // one directed frame
    typedef struct {
        int                 noise_pulses;
        bit                 saturated_noise;
        logic [7:0]         cmd;
        bit                 crc_good;
        logic [7:0]         crc_field;
        int                 cmd_bits;
        int                 crc_bits;
        len_style_t         style;
        bit                 typed;
        logic [7:0]         want_data;
        irpw_pkg::status_t  want_status;
    } frame_row_t;

    logic clk = 1'b0;
    logic rst_n;

    irpw_line_if  line_ch ();
    irpw_frame_if frame_ch ();
    irpw_cfg_if   cfg_ch ();

    ir_pulse_width_receiver_crc8 #(
        .BITS_PER_FIELD (FIELD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .line  (line_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    // decoder copy: registers and frame state
    logic [irpw_pkg::TOL_W-1:0] tol_q   = irpw_pkg::TOLERANCE_RESET;
    logic [irpw_pkg::LEN_W-1:0] start_q = irpw_pkg::START_LENGTH_RESET;
    logic [irpw_pkg::LEN_W-1:0] zero_q  = irpw_pkg::ZERO_LENGTH_RESET;
    logic [irpw_pkg::LEN_W-1:0] one_q   = irpw_pkg::ONE_LENGTH_RESET;
    logic                       prev_level_q = 1'b0;
    logic [irpw_pkg::LEN_W-1:0] len_q   = '0;
    irpw_pkg::phase_t           phase_q = irpw_pkg::PHASE_HUNT;
    logic [3:0]                 pos_q   = '0;
    logic [7:0]                 cmd_q   = '0;
    logic [7:0]                 crc_q   = '0;

    irpw_pkg::result_t frames_due[$];
    irpw_pkg::result_t typed_due;
    bit         typed_armed = 1'b0;
    int         mismatch_count = 0;
    int         frames_seen = 0;

    bit         sender_idles = 1'b0;
    bit         sink_stalls = 1'b0;
    bit         hold_request = 1'b0;
    int         hold_left = 0;
    int         stall_left = 0;

    frame_row_t directed_rows[$];

    // clock
    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // run limit
    initial
    begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("ir_pulse_width_receiver_crc8: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("error at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic bit in_window(input logic [7:0] len, input logic [7:0] nominal);
        int l;
        int n;
        int t;
        l = int'(len);
        n = int'(nominal);
        t = int'(tol_q);
        return (l >= n - t) && (l <= n + t);
    endfunction

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic b);
        logic fb;
        fb = crc[0] ^ b;
        crc = crc >> 1;
        if (fb)
            crc = crc ^ irpw_pkg::CRC_POLY;
        return crc;
    endfunction

    function automatic logic [7:0] crc8_of_byte(input logic [7:0] value);
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < 8; i++)
            crc = crc8_step(crc, value[i]);
        return crc;
    endfunction

    // advance the decoder copy by one line sample, queue a frame when one closes
    task automatic decode_sample(input logic level);
        logic [7:0]        ended;
        bit                is_start;
        bit                bit_val;
        irpw_pkg::result_t res;
        if (level)
        begin
            if (len_q != irpw_pkg::LEN_MAX)
                len_q++;
        end
        else if (prev_level_q)
        begin
            ended = len_q;
            is_start = in_window(ended, start_q);
            len_q = '0;
            if (phase_q == irpw_pkg::PHASE_CMD || phase_q == irpw_pkg::PHASE_CRC)
            begin
                if (is_start)
                begin
                    if (phase_q == irpw_pkg::PHASE_CMD)
                    begin
                        phase_q = irpw_pkg::PHASE_CRC;
                        pos_q = '0;
                    end
                    else
                    begin
                        res.data_byte = cmd_q;
                        if (crc_q != 8'h00)
                            res.frame_status = irpw_pkg::STATUS_CRC_ERROR;
                        else if (cmd_q == 8'h00)
                            res.frame_status = irpw_pkg::STATUS_ZERO_BYTE;
                        else
                            res.frame_status = irpw_pkg::STATUS_ACCEPTED;
                        if (typed_armed)
                        begin
                            res = typed_due;
                            typed_armed = 1'b0;
                        end
                        frames_due.push_back(res);
                        phase_q = irpw_pkg::PHASE_HUNT;
                        pos_q = '0;
                    end
                end
                else if (pos_q < FIELD_BITS)
                begin
                    // zero wins over one; anything else is a 0 bit
                    bit_val = !in_window(ended, zero_q) && in_window(ended, one_q);
                    if (phase_q == irpw_pkg::PHASE_CMD && bit_val)
                        cmd_q[pos_q[2:0]] = 1'b1;
                    crc_q = crc8_step(crc_q, bit_val);
                    pos_q++;
                end
            end
            else if (is_start)
            begin
                phase_q = irpw_pkg::PHASE_CMD;
                pos_q = '0;
                cmd_q = '0;
                crc_q = '0;
            end
        end
        prev_level_q = level;
    endtask

    // sample every transfer on the rising edge
    always @(posedge clk)
    begin : watch
        irpw_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (irpw_pkg::cfg_index_t'(cfg_ch.index))
                    irpw_pkg::CFG_TOLERANCE:    tol_q = cfg_ch.data[irpw_pkg::TOL_W-1:0];
                    irpw_pkg::CFG_START_LENGTH: start_q = cfg_ch.data;
                    irpw_pkg::CFG_ZERO_LENGTH:  zero_q = cfg_ch.data;
                    irpw_pkg::CFG_ONE_LENGTH:   one_q = cfg_ch.data;
                    default: ;
                endcase
            end
            if (line_ch.valid && line_ch.ready)
                decode_sample(line_ch.line_active);
            if (frame_ch.valid && frame_ch.ready)
            begin
                frames_seen++;
                if (frames_due.size() == 0)
                begin
                    report_mismatch($sformatf("frame %0d not expected: data_byte %h status %0d",
                        frames_seen, frame_ch.data_byte, frame_ch.frame_status));
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (frame_ch.data_byte !== want.data_byte)
                        report_mismatch($sformatf("frame %0d: data_byte %h, expected %h",
                            frames_seen, frame_ch.data_byte, want.data_byte));
                    if (frame_ch.frame_status !== want.frame_status)
                        report_mismatch($sformatf("frame %0d: frame_status %0d, expected %0d",
                            frames_seen, frame_ch.frame_status, want.frame_status));
                end
                stall_left = sink_stalls ? int'($urandom_range(6, 0)) : 0;
            end
        end
    end

    // frame sink: per-transfer stalls plus the long hold-off
    initial
    begin
        frame_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                frame_ch.ready <= 1'b0;
            end
            else
            begin
                frame_ch.ready <= 1'b1;
            end
        end
    end

    // one line sample, entered and left at a falling edge
    task automatic send_sample(input logic level);
        int gap;
        gap = sender_idles ? int'($urandom_range(6, 0)) : 0;
        if (gap > 0)
        begin
            line_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        line_ch.valid <= 1'b1;
        line_ch.line_active <= level;
        @(posedge clk);
        while (!line_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pulse(input int ticks);
        repeat (ticks) send_sample(1'b1);
        repeat ($urandom_range(3, 1)) send_sample(1'b0);
    endtask

    function automatic int window_len(input logic [7:0] nominal, input bit at_edge);
        int lo;
        int hi;
        lo = int'(nominal) - int'(tol_q);
        hi = int'(nominal) + int'(tol_q);
        if (lo < 1)
            lo = 1;
        if (at_edge)
            return $urandom_range(1, 0) ? lo : hi;
        return int'($urandom_range(hi, lo));
    endfunction

    // a length just outside the class window
    function automatic int unfit_len(input logic [7:0] nominal);
        int below;
        below = int'(nominal) - int'(tol_q) - 1;
        if (below >= 1 && $urandom_range(1, 0))
            return below;
        return int'(nominal) + int'(tol_q) + 1;
    endfunction

    function automatic int start_ticks();
        // saturated start pulse when the window reaches the counter limit
        if (int'(start_q) + int'(tol_q) >= int'(irpw_pkg::LEN_MAX) && $urandom_range(3, 0) == 0)
            return int'(irpw_pkg::LEN_MAX) + int'($urandom_range(30, 1));
        return window_len(start_q, 1'b0);
    endfunction

    function automatic int bit_ticks(input logic b, input len_style_t style);
        case (style)
            LEN_EDGE:  return window_len(b ? one_q : zero_q, 1'b1);
            LEN_UNFIT: return b ? window_len(one_q, 1'b0) : unfit_len(zero_q);
            default:   return window_len(b ? one_q : zero_q, 1'b0);
        endcase
    endfunction

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] crc_field,
                              input int cmd_bits, input int crc_bits,
                              input len_style_t style, input bit closing);
        send_pulse(start_ticks());
        for (int i = 0; i < cmd_bits; i++)
            send_pulse(bit_ticks(cmd[i % 8], style));
        send_pulse(start_ticks());
        for (int i = 0; i < crc_bits; i++)
            send_pulse(bit_ticks(crc_field[i % 8], style));
        if (closing)
            send_pulse(start_ticks());
    endtask

    // mostly well-formed frames, some noise and broken frames
    task automatic send_random_frame();
        int         pick;
        logic [7:0] cmd;
        logic [7:0] crc_field;
        int         cmd_bits;
        int         crc_bits;
        len_style_t style;
        pick = int'($urandom_range(99, 0));
        if (pick < 5)
        begin
            repeat ($urandom_range(40, 8)) send_sample(1'($urandom_range(1, 0)));
            return;
        end
        if (pick < 8)
            send_pulse(int'(irpw_pkg::LEN_MAX) + int'($urandom_range(20, 1)));
        if (pick < 20)
            repeat ($urandom_range(3, 1))
                send_pulse(bit_ticks(1'($urandom_range(1, 0)), LEN_UNFIT));
        cmd = 8'($urandom);
        crc_field = ($urandom_range(4, 0) != 0) ? crc8_of_byte(cmd) : 8'($urandom);
        cmd_bits = ($urandom_range(6, 0) != 0) ? FIELD_BITS
                                               : int'($urandom_range(FIELD_BITS + 3, 0));
        crc_bits = ($urandom_range(6, 0) != 0) ? FIELD_BITS
                                               : int'($urandom_range(FIELD_BITS + 3, 0));
        case ($urandom_range(9, 0))
            0:       style = LEN_EDGE;
            1:       style = LEN_UNFIT;
            default: style = LEN_NOMINAL;
        endcase
        send_frame(cmd, crc_field, cmd_bits, crc_bits, style, $urandom_range(19, 0) != 0);
    endtask

    // stop the line, wait for every queued frame, then let the pipeline empty
    task automatic drain_frames();
        int waited;
        waited = 0;
        line_ch.valid <= 1'b0;
        while (frames_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (frames_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d frames never arrived", frames_due.size()));
            frames_due.delete();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input irpw_pkg::cfg_index_t idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // new register set on an idle block, then a run of random frames
    task automatic run_phase(input logic [7:0] tol_raw, input logic [7:0] start_len,
                             input logic [7:0] zero_len, input logic [7:0] one_len,
                             input int frames, input bit pressure);
        drain_frames();
        write_reg(irpw_pkg::CFG_TOLERANCE, tol_raw);
        write_reg(irpw_pkg::CFG_START_LENGTH, start_len);
        write_reg(irpw_pkg::CFG_ZERO_LENGTH, zero_len);
        write_reg(irpw_pkg::CFG_ONE_LENGTH, one_len);
        cfg_ch.valid <= 1'b0;
        for (int f = 0; f < frames; f++)
        begin
            sender_idles = $urandom_range(3, 0) != 0;
            sink_stalls = $urandom_range(3, 0) != 0;
            if (pressure && f >= HOLD_FRAME && f < HOLD_FRAME + 4)
                sender_idles = 1'b0;
            // long hold-off while frames keep coming
            if (pressure && f == HOLD_FRAME)
            begin
                line_ch.valid <= 1'b0;
                @(posedge clk);
                hold_request = 1'b1;
                @(negedge clk);
            end
            send_random_frame();
        end
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        line_ch.valid = 1'b0;
        line_ch.line_active = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = irpw_pkg::CFG_TOLERANCE;
        cfg_ch.data = '0;

        // directed frames, the first under the reset register values
        directed_rows.push_back(frame_row_t'{2, 1'b0, 8'h00, 1'b1, 8'h00, 8, 8, LEN_NOMINAL,
                                             1'b1, 8'h00, irpw_pkg::STATUS_ZERO_BYTE});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'hFF, 1'b1, 8'h00, 8, 8, LEN_NOMINAL,
                                             1'b1, 8'hFF, irpw_pkg::STATUS_ACCEPTED});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'h01, 1'b0, 8'h00, 8, 8, LEN_NOMINAL,
                                             1'b1, 8'h01, irpw_pkg::STATUS_CRC_ERROR});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'h00, 1'b0, 8'h01, 8, 8, LEN_NOMINAL,
                                             1'b1, 8'h00, irpw_pkg::STATUS_CRC_ERROR});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'hA5, 1'b1, 8'h00, 8, 8, LEN_EDGE,
                                             1'b0, 8'h00, irpw_pkg::STATUS_ACCEPTED});
        directed_rows.push_back(frame_row_t'{1, 1'b0, 8'h3C, 1'b1, 8'h00, 8, 8, LEN_UNFIT,
                                             1'b0, 8'h00, irpw_pkg::STATUS_ACCEPTED});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'h5A, 1'b1, 8'h00, 10, 11, LEN_NOMINAL,
                                             1'b0, 8'h00, irpw_pkg::STATUS_ACCEPTED});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'h1F, 1'b1, 8'h00, 5, 8, LEN_NOMINAL,
                                             1'b0, 8'h00, irpw_pkg::STATUS_ACCEPTED});
        directed_rows.push_back(frame_row_t'{0, 1'b1, 8'h80, 1'b1, 8'h00, 8, 8, LEN_NOMINAL,
                                             1'b0, 8'h00, irpw_pkg::STATUS_ACCEPTED});
        directed_rows.push_back(frame_row_t'{0, 1'b0, 8'h00, 1'b1, 8'h00, 0, 0, LEN_NOMINAL,
                                             1'b1, 8'h00, irpw_pkg::STATUS_ZERO_BYTE});
        directed_rows.push_back(frame_row_t'{3, 1'b0, 8'hC3, 1'b1, 8'h00, 8, 1, LEN_EDGE,
                                             1'b0, 8'h00, irpw_pkg::STATUS_ACCEPTED});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            // later rows run on short exact pulse lengths
            if (i == 1)
                run_phase(8'd0, 8'd5, 8'd1, 8'd3, 0, 1'b0);
            sender_idles = 1'($urandom_range(1, 0));
            sink_stalls = 1'($urandom_range(1, 0));
            if (directed_rows[i].typed)
            begin
                typed_due.data_byte = directed_rows[i].want_data;
                typed_due.frame_status = directed_rows[i].want_status;
                typed_armed = 1'b1;
            end
            if (directed_rows[i].saturated_noise)
                send_pulse(int'(irpw_pkg::LEN_MAX) + 2);
            repeat (directed_rows[i].noise_pulses)
                send_pulse(bit_ticks(1'($urandom_range(1, 0)), LEN_NOMINAL));
            send_frame(directed_rows[i].cmd,
                       directed_rows[i].crc_good ? crc8_of_byte(directed_rows[i].cmd)
                                                 : directed_rows[i].crc_field,
                       directed_rows[i].cmd_bits, directed_rows[i].crc_bits,
                       directed_rows[i].style, 1'b1);
            typed_armed = 1'b0;
        end

        // dropped tolerance bits with overlapping classes, pressure, random, clipped window
        run_phase(8'hC3, 8'd8, 8'd4, 8'd6, 1, 1'b0);
        run_phase(8'd0, 8'd4, 8'd1, 8'd2, 5, 1'b1);
        run_phase(8'($urandom_range(3, 0)), 8'($urandom_range(16, 10)),
                  8'($urandom_range(3, 1)), 8'($urandom_range(8, 5)), 2, 1'b0);
        run_phase(8'd5, 8'd3, 8'd16, 8'd10, 1, 1'b0);

        drain_frames();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("ir_pulse_width_receiver_crc8: match");
        else
            $display("ir_pulse_width_receiver_crc8: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/irpw_pkg.sv
hw/rtl/irpw_if.sv
hw/rtl/irpw_classify.sv
hw/rtl/irpw_frame.sv
hw/rtl/ir_pulse_width_receiver_crc8.sv
tb/sv/ir_pulse_width_receiver_crc8_test.sv
